[rtl/core/safc_pkg.sv]
// ============================================================================
// safc_pkg
// Shared widths, reset values, register indexes and types for the
// set-associative FIFO-replacement tag unit.
// ============================================================================
`default_nettype none

package safc_pkg;

    localparam int ADDR_W    = 32;
    localparam int TAG_W     = 32;
    localparam int CNT_W     = 32;
    localparam int SET_OUT_W = 8;
    localparam int SET_RAW_N = 256;   // codes of the 8-bit raw set field

    localparam int OFF_W = 5;
    localparam int IDX_W = 4;
    localparam int WAYS_W = 4;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [OFF_W-1:0]  OFF_MAX = 5'd16;
    localparam logic [IDX_W-1:0]  IDX_MAX = 4'd8;

    localparam logic [OFF_W-1:0]  OFF_RESET  = 5'd6;
    localparam logic [IDX_W-1:0]  IDX_RESET  = 4'd4;
    localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd4;

    localparam int MAX_SETS_DEF = 256;
    localparam int MAX_WAYS_DEF = 8;
    localparam int QUEUE_DEPTH  = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0]  offset_bits;
        logic [IDX_W-1:0]  index_bits;
        logic [WAYS_W-1:0] ways_in_use;
        logic              flush;       // empty every set this cycle
    } safc_cfg_t;

endpackage

`default_nettype wire

[rtl/core/safc_ram.sv]
// ============================================================================
// safc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds when no read is issued.
// ============================================================================
`default_nettype none

module safc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/safc_queue.sv]
// ============================================================================
// safc_queue
// Small register FIFO between the classify front and the lookup back.
// ============================================================================
`default_nettype none

module safc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic      [WIDTH-1:0] head_data
);

    logic [WIDTH-1:0] ent_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign head_data = ent_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            ent_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/safc_front.sv]
// ============================================================================
// safc_front
// Accepts addresses, splits them into set and tag under the current
// offset/index widths and queues them for the lookup back end.
// ============================================================================
`default_nettype none

module safc_front import safc_pkg::*; #(
    parameter int MAX_SETS = MAX_SETS_DEF,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int ENT_W = SET_W + TAG_W
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire safc_cfg_t         cfg,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ADDR_W-1:0] s_address,
    input  wire logic              q_pop,
    output logic                   q_valid,
    output logic      [ENT_W-1:0]  q_data
);

    logic [OFF_W-1:0]     off_eff;
    logic [IDX_W-1:0]     idx_eff;
    logic [ADDR_W-1:0]    shifted;
    logic [SET_OUT_W-1:0] set_raw;
    logic [TAG_W-1:0]     tag;
    logic [SET_W-1:0]     set_wrap;
    logic [SET_W-1:0]     set_wrap_tab [SET_RAW_N];
    logic                 q_full;

    // raw set code folded into the sets that exist
    for (genvar g = 0; g < SET_RAW_N; g++) begin : g_wrap
        assign set_wrap_tab[g] = SET_W'(g % MAX_SETS);
    end

    assign off_eff  = (cfg.offset_bits > OFF_MAX) ? OFF_MAX : cfg.offset_bits;
    assign idx_eff  = (cfg.index_bits > IDX_MAX) ? IDX_MAX : cfg.index_bits;
    assign shifted  = s_address >> off_eff;
    assign set_raw  = shifted[SET_OUT_W-1:0] & ~(8'hFF << idx_eff);
    assign tag      = s_address >> (6'(off_eff) + 6'(idx_eff));
    assign set_wrap = set_wrap_tab[set_raw];
    assign s_ready  = !q_full;

    safc_queue #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data ({set_wrap, tag}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_data (q_data)
    );

endmodule

`default_nettype wire

[rtl/core/safc_back.sv]
// ============================================================================
// safc_back
// Lookup engine: reads a set row, compares tags over the live FIFO window,
// writes the updated row back on a miss and keeps the running counters.
// ============================================================================
`default_nettype none

module safc_back import safc_pkg::*; #(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF,
    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1,
    localparam int ENT_W = SET_W + TAG_W
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire safc_cfg_t            cfg,
    input  wire logic                 q_valid,
    input  wire logic [ENT_W-1:0]     q_data,
    output logic                      q_pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_hit,
    output logic      [SET_OUT_W-1:0] m_set_index,
    output logic      [CNT_W-1:0]     m_access_total,
    output logic      [CNT_W-1:0]     m_hit_total
);

    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W = $clog2(MAX_WAYS + 1);
    localparam int CW     = FILL_W + 1;            // room for head + fill
    localparam int TAGS_W = MAX_WAYS * TAG_W;
    localparam int ROW_W  = TAGS_W + FILL_W + WAY_W;

    localparam logic ST_FETCH = 1'b0;
    localparam logic ST_EVAL  = 1'b1;

    logic                st_reg, st_next;
    logic [SET_W-1:0]    set_reg;
    logic [TAG_W-1:0]    tag_reg;
    logic                vld_reg;
    logic [MAX_SETS-1:0] set_vld_reg, set_vld_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_hit_reg;
    logic [SET_W-1:0]    out_set_reg;
    logic [CNT_W-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]    hit_reg, hit_next;

    logic [SET_W-1:0]    q_set;
    logic [ROW_W-1:0]    rd_row, wr_row;
    logic                commit, ram_we;
    logic [CW-1:0]       ways_x, fill_x, head_x, ins_x, victim_x, head_n, fill_n;
    logic [CW-1:0]       wx, span_x;
    logic [MAX_WAYS-1:0] match;
    logic                hit_c, full_c;

    assign q_set  = q_data[ENT_W-1 -: SET_W];
    assign q_pop  = (st_reg == ST_FETCH) && q_valid;
    assign commit = (st_reg == ST_EVAL) && (!m_valid_reg || m_ready);
    assign ram_we = commit && !hit_c;

    safc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (set_reg),
        .wr_data (wr_row),
        .rd_en   (q_pop),
        .rd_addr (q_set),
        .rd_data (rd_row)
    );

    // effective associativity, fill and head of the selected set
    always_comb begin
        if (cfg.ways_in_use == '0) begin
            ways_x = CW'(1);
        end else if (32'(cfg.ways_in_use) > 32'(MAX_WAYS)) begin
            ways_x = CW'(MAX_WAYS);
        end else begin
            ways_x = CW'(cfg.ways_in_use);
        end
        fill_x = vld_reg ? CW'(rd_row[TAGS_W +: FILL_W]) : '0;
        if (fill_x > ways_x) begin
            fill_x = ways_x;
        end
        head_x = vld_reg ? CW'(rd_row[ROW_W-1 -: WAY_W]) : '0;
        if (head_x >= ways_x) begin
            head_x = '0;
        end
    end

    // a way is live when its distance from the head is below the fill
    always_comb begin
        wx     = '0;
        span_x = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            wx       = CW'(w);
            span_x   = (wx >= head_x) ? (wx - head_x) : (wx + ways_x - head_x);
            match[w] = (wx < ways_x) && (span_x < fill_x)
                    && (rd_row[w*TAG_W +: TAG_W] == tag_reg);
        end
    end

    assign hit_c = |match;
    assign full_c = (fill_x == ways_x);

    always_comb begin
        ins_x = head_x + fill_x;
        if (ins_x >= ways_x) begin
            ins_x = ins_x - ways_x;
        end
        if (full_c) begin
            victim_x = head_x;
            head_n   = (head_x + 1'b1 >= ways_x) ? '0 : head_x + 1'b1;
            fill_n   = fill_x;
        end else begin
            victim_x = ins_x;
            head_n   = head_x;
            fill_n   = fill_x + 1'b1;
        end
        wr_row = rd_row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (CW'(w) == victim_x) begin
                wr_row[w*TAG_W +: TAG_W] = tag_reg;
            end
        end
        wr_row[TAGS_W +: FILL_W]      = FILL_W'(fill_n);
        wr_row[ROW_W-1 -: WAY_W]      = WAY_W'(head_n);
    end

    always_comb begin
        st_next      = st_reg;
        set_vld_next = set_vld_reg;
        m_valid_next = m_valid_reg;
        acc_next     = acc_reg;
        hit_next     = hit_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        case (st_reg)
            ST_FETCH: begin
                if (q_valid) begin
                    st_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (commit) begin
                    st_next      = ST_FETCH;
                    m_valid_next = 1'b1;
                    acc_next     = (acc_reg == '1) ? acc_reg : acc_reg + 1'b1;
                    if (hit_c) begin
                        hit_next = (hit_reg == '1) ? hit_reg : hit_reg + 1'b1;
                    end else begin
                        set_vld_next[set_reg] = 1'b1;
                    end
                end
            end
            default: begin
                st_next = ST_FETCH;
            end
        endcase
        if (cfg.flush) begin
            set_vld_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_FETCH;
            set_vld_reg <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            hit_reg     <= '0;
        end else begin
            st_reg      <= st_next;
            set_vld_reg <= set_vld_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            set_reg <= q_set;
            tag_reg <= q_data[TAG_W-1:0];
            vld_reg <= set_vld_reg[q_set];
        end
        if (commit) begin
            out_hit_reg <= hit_c;
            out_set_reg <= set_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_hit          = out_hit_reg;
    assign m_set_index    = SET_OUT_W'(out_set_reg);
    assign m_access_total = acc_reg;
    assign m_hit_total    = hit_reg;

    // hits never outnumber accesses
    a_hit_le_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_reg <= acc_reg)
        else $error("hit count above access count");

    // a hit needs at least one live way
    a_hit_needs_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EVAL && hit_c) |-> (fill_x != '0))
        else $error("hit on an empty set");

    // a written row never claims more tags than ways
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (fill_n <= ways_x && head_n < ways_x))
        else $error("row update out of range");

    // no new read while a row is being evaluated
    a_no_read_in_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == ST_EVAL) |-> !q_pop)
        else $error("read issued during evaluation");

    // every commit presents a result next cycle
    a_commit_out: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |=> m_valid_reg)
        else $error("result lost after commit");

endmodule

`default_nettype wire

[rtl/core/set_assoc_cache_fifo_tags_unit.sv]
// ============================================================================
// set_assoc_cache_fifo_tags_unit
// Set-associative cache tag tracker with FIFO replacement and running
// access/hit counters.
// ============================================================================
//
//  Port group | Direction | Handshake           | Payload
//  -----------+-----------+---------------------+-------------------------------
//  s_*        | in        | s_valid / s_ready   | s_address[31:0]
//  m_*        | out       | m_valid / m_ready   | m_hit, m_set_index[7:0],
//             |           |                     | m_access_total, m_hit_total
//  cfg_*      | in        | cfg_wr_en (no wait) | cfg_addr[1:0], cfg_wr_data[4:0]
//
//  Each item is a read-modify-write of its set row: the row is read in the
//  fetch step, then compared and written back in the evaluate step, and
//  the back end fetches a new item only after it has committed the last.
//  m_valid rises after an item has left the queue and been evaluated.
//  Reset and any write to a listed register empty every set through a
//  per-set valid vector; no memory sweep is needed. Counters survive
//  register writes.
//  A 2-item queue decouples input from lookup; a stalled output holds the
//  back end in its evaluate step while the queue keeps taking items until
//  it holds two.
//
`default_nettype none

module set_assoc_cache_fifo_tags_unit import safc_pkg::*; #(
    parameter int MAX_SETS = MAX_SETS_DEF,
    parameter int MAX_WAYS = MAX_WAYS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    // address items in
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ADDR_W-1:0]     s_address,

    // result items out
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_hit,
    output logic      [SET_OUT_W-1:0]  m_set_index,
    output logic      [CNT_W-1:0]      m_access_total,
    output logic      [CNT_W-1:0]      m_hit_total,

    // register writes
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENT_W = SET_W + TAG_W;

    logic [OFF_W-1:0]  off_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [WAYS_W-1:0] ways_reg;
    logic              cfg_hit;
    safc_cfg_t         cfg;

    logic              q_valid, q_pop;
    logic [ENT_W-1:0]  q_data;

    // only listed registers flush the sets; index 3 is ignored
    assign cfg_hit = cfg_wr_en && (cfg_addr == CFG_OFFSET_BITS
                                || cfg_addr == CFG_INDEX_BITS
                                || cfg_addr == CFG_WAYS_IN_USE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_reg  <= OFF_RESET;
            idx_reg  <= IDX_RESET;
            ways_reg <= WAYS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_OFFSET_BITS: off_reg  <= cfg_wr_data[OFF_W-1:0];
                CFG_INDEX_BITS:  idx_reg  <= cfg_wr_data[IDX_W-1:0];
                CFG_WAYS_IN_USE: ways_reg <= cfg_wr_data[WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.offset_bits = off_reg;
    assign cfg.index_bits  = idx_reg;
    assign cfg.ways_in_use = ways_reg;
    assign cfg.flush       = cfg_hit;

    // front: split address, queue it
    safc_front #(
        .MAX_SETS (MAX_SETS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_address (s_address),
        .q_pop     (q_pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    // back: row read, tag compare, FIFO update, counters
    safc_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_set_index    (m_set_index),
        .m_access_total (m_access_total),
        .m_hit_total    (m_hit_total)
    );

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench for set_assoc_cache_fifo_tags_unit
// Sends address items through the valid/ready input and checks every result
// against a cycle-free model of the tag store. The model splits each address
// into offset, set and tag, looks the tag up, appends or evicts in FIFO order,
// and keeps the running access and hit counts. The run starts with directed
// items, then goes through phases of random items, each phase under a new
// register setting. Both sides of the link idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import safc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 500000;
    localparam int N_PHASES    = 8;
    localparam int PHASE_ITEMS = 80;
    localparam int ROWS        = 256;
    localparam int WAYS        = 8;
    localparam int BUF_DEPTH   = 1024;
    // register index past the end of the list; a write there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [7:0]        set_index;
        logic [CNT_W-1:0]  access_total;
        logic [CNT_W-1:0]  hit_total;
    } lookup_result_t;

    // DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_address = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b1;
    logic                  m_hit;
    logic [SET_OUT_W-1:0]  m_set_index;
    logic [CNT_W-1:0]      m_access_total;
    logic [CNT_W-1:0]      m_hit_total;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    set_assoc_cache_fifo_tags_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_address      (s_address),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_set_index    (m_set_index),
        .m_access_total (m_access_total),
        .m_hit_total    (m_hit_total),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wr_data    (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // Tag store model: registers, rows, FIFO heads and counters
    // ------------------------------------------------------------------
    logic [OFF_W-1:0]  cfg_off  = OFF_RESET;
    logic [IDX_W-1:0]  cfg_idx  = IDX_RESET;
    logic [WAYS_W-1:0] cfg_ways = WAYS_RESET;

    logic [TAG_W-1:0]  tag_rows [ROWS][WAYS];
    int unsigned       row_fill [ROWS];
    int unsigned       row_head [ROWS];
    logic [CNT_W-1:0]  access_count = '0;
    logic [CNT_W-1:0]  hit_count = '0;

    // addresses waiting to be driven, as a ring with running indexes
    logic [ADDR_W-1:0] access_buf [BUF_DEPTH];
    int                acc_wr = 0;
    int                acc_rd = 0;
    // results owed by the DUT
    lookup_result_t    owed_buf [BUF_DEPTH];
    int                owed_wr = 0;
    int                owed_rd = 0;

    int n_in_driven    = 0;
    int n_in_accepted  = 0;
    int n_out_accepted = 0;
    int n_out_seen     = 0;
    int n_errors       = 0;
    int cycle_count    = 0;
    int n_cfg_writes   = 0;
    bit quiet_link     = 1'b0;   // no idling on either side while set

    // sender and receiver pacing
    int send_gap     = 0;
    bit send_gap_set = 1'b0;
    int recv_stall   = 0;

    function automatic void queue_access(input logic [ADDR_W-1:0] addr);
        access_buf[acc_wr % BUF_DEPTH] = addr;
        acc_wr++;
    endfunction

    // clamped geometry, as the hardware interprets the registers
    function automatic int unsigned eff_off();
        return (cfg_off > OFF_MAX) ? OFF_MAX : cfg_off;
    endfunction

    function automatic int unsigned eff_idx();
        return (cfg_idx > IDX_MAX) ? IDX_MAX : cfg_idx;
    endfunction

    function automatic int unsigned eff_ways();
        if (cfg_ways == 0)
            return 1;
        return (cfg_ways > WAYS) ? WAYS : cfg_ways;
    endfunction

    function automatic void empty_rows();
        for (int r = 0; r < ROWS; r++) begin
            row_fill[r] = 0;
            row_head[r] = 0;
        end
    endfunction

    function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_OFFSET_BITS: cfg_off  = data;
            CFG_INDEX_BITS:  cfg_idx  = data[IDX_W-1:0];
            CFG_WAYS_IN_USE: cfg_ways = data[WAYS_W-1:0];
            default: return;
        endcase
        // counters survive, the sets do not
        empty_rows();
    endfunction

    // one access: look the tag up, update the row, bump the counters
    function automatic lookup_result_t look_up(input logic [ADDR_W-1:0] addr);
        int unsigned off, idx, ways, row, fill, head;
        logic [TAG_W-1:0] tag;
        bit found;
        lookup_result_t res;
        off  = eff_off();
        idx  = eff_idx();
        ways = eff_ways();
        row  = (addr >> off) & ((32'd1 << idx) - 1);
        tag  = addr >> (off + idx);
        fill = row_fill[row];
        head = row_head[row];
        if (fill > ways)
            fill = ways;
        if (head >= ways)
            head = 0;
        if (access_count != '1)
            access_count++;
        found = 1'b0;
        for (int i = 0; i < fill; i++) begin
            if (!found && tag_rows[row][(head + i) % ways] == tag)
                found = 1'b1;
        end
        if (found) begin
            if (hit_count != '1)
                hit_count++;
        end else if (fill < ways) begin
            tag_rows[row][(head + fill) % ways] = tag;
            row_fill[row] = fill + 1;
        end else begin
            tag_rows[row][head] = tag;
            row_head[row] = (head + 1) % ways;
        end
        res.hit          = found;
        res.set_index    = row[7:0];
        res.access_total = access_count;
        res.hit_total    = hit_count;
        return res;
    endfunction

    // builds an address that decodes to the given tag and set
    function automatic logic [ADDR_W-1:0] make_addr(input logic [31:0] tag,
                                                    input int unsigned row,
                                                    input logic [31:0] low_bits);
        int unsigned off, idx;
        off = eff_off();
        idx = eff_idx();
        return (tag << (off + idx)) | ((row & ((32'd1 << idx) - 1)) << off)
             | (low_bits & ((32'd1 << off) - 1));
    endfunction

    function automatic int draw_wait();
        return quiet_link ? 0 : $urandom_range(0, 17);
    endfunction

    function automatic void check_field(input string field,
                                        input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            n_errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------
    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_count, owed_wr - owed_rd);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender: one item at a time from access_buf, random gap before each.
    // s_valid holds until the posedge monitor has counted the handshake.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || n_in_accepted == n_in_driven) begin
            if (acc_wr == acc_rd) begin
                s_valid <= 1'b0;
            end else begin
                if (!send_gap_set) begin
                    send_gap = draw_wait();
                    send_gap_set = 1'b1;
                end
                if (send_gap == 0) begin
                    s_valid   <= 1'b1;
                    s_address <= access_buf[acc_rd % BUF_DEPTH];
                    acc_rd++;
                    n_in_driven++;
                    send_gap_set = 1'b0;
                end else begin
                    send_gap--;
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: after each result taken, drop ready for a random stall
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (n_out_accepted != n_out_seen) begin
            n_out_seen = n_out_accepted;
            recv_stall = draw_wait();
        end
        if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results first, then predict for a newly taken address
    // (a result can never belong to an item taken on the same edge).
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lookup_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_out_accepted++;
                if (owed_wr == owed_rd) begin
                    n_errors++;
                    $display("%0t ns: unexpected result, expected none, actual hit=%0b set=%0h",
                             $time, m_hit, m_set_index);
                end else begin
                    want = owed_buf[owed_rd % BUF_DEPTH];
                    owed_rd++;
                    check_field("hit",          want.hit,          m_hit);
                    check_field("set_index",    want.set_index,    m_set_index);
                    check_field("access_total", want.access_total, m_access_total);
                    check_field("hit_total",    want.hit_total,    m_hit_total);
                end
            end
            if (s_valid && s_ready) begin
                n_in_accepted++;
                owed_buf[owed_wr % BUF_DEPTH] = look_up(s_address);
                owed_wr++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= data;
        apply_reg(idx, data);
        n_cfg_writes++;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every item is taken and every result is back
    task automatic drain();
        while (acc_wr != acc_rd || n_in_accepted != n_in_driven)
            @(posedge aclk);
        while (owed_wr != owed_rd)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [31:0] tag_pool [12];
        int unsigned n_tags, row_base, pick;
        empty_rows();

        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(posedge aclk);

        // --- directed, reset geometry: 64-byte blocks, 16 sets, 4 ways
        queue_access(32'h0000_0000);                      // cold miss
        queue_access(32'h0000_003F);                      // same block: hit
        queue_access(32'hFFFF_FFFF);                      // all ones
        for (int t = 1; t <= 4; t++)                      // fill set 3
            queue_access(make_addr(t, 3, 0));
        queue_access(make_addr(5, 3, 0));                 // full: evicts tag 1
        queue_access(make_addr(1, 3, 0));                 // gone: miss, evicts 2
        queue_access(make_addr(3, 3, 7));                 // still there
        queue_access(make_addr(5, 3, 1));
        drain();

        // write past the register list: sets must survive
        write_reg(CFG_UNUSED, 5'h1F);
        queue_access(make_addr(4, 3, 0));
        drain();

        // oversized values clamp: offset 16, index 8, zero ways acts as one
        write_reg(CFG_OFFSET_BITS, 5'h1F);
        write_reg(CFG_INDEX_BITS, 5'h1F);
        write_reg(CFG_WAYS_IN_USE, 5'h00);
        queue_access(32'h1234_0000);
        queue_access(32'h1234_FFFF);                      // hit
        queue_access(32'h1334_0000);                      // one way: evicts
        queue_access(32'h1234_0000);                      // miss again
        drain();

        // no offset, one set, ways 15 clamps to 8
        write_reg(CFG_OFFSET_BITS, 5'd0);
        write_reg(CFG_INDEX_BITS, 5'd0);
        write_reg(CFG_WAYS_IN_USE, 5'd15);
        for (int t = 1; t <= 9; t++)                      // ninth evicts the first
            queue_access(t);
        queue_access(32'd1);                              // miss, evicts 2
        queue_access(32'd3);                              // hit
        drain();

        // --- random phases, new geometry each time
        for (int p = 0; p < N_PHASES; p++) begin
            pick = $urandom_range(0, 3);
            write_reg(CFG_OFFSET_BITS, (pick == 0) ? 5'd0 :
                                       (pick == 1) ? (($urandom_range(0, 1) != 0) ? 5'd16 : 5'd31) :
                                       5'($urandom_range(2, 12)));
            write_reg(CFG_INDEX_BITS, 5'($urandom_range(0, 31)));
            write_reg(CFG_WAYS_IN_USE, (p == 0) ? 5'd8 : (p == 1) ? 5'd1 :
                                       5'($urandom_range(0, 31)));
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_UNUSED, 5'($urandom_range(0, 31)));
            quiet_link = ($urandom_range(0, 2) == 0);

            // small tag pool over a few neighboring sets, so hits and
            // evictions are common
            n_tags = eff_ways() + 3;
            for (int i = 0; i < n_tags; i++)
                tag_pool[i] = $urandom();
            row_base = $urandom_range(0, 255);
            @(posedge aclk);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if ($urandom_range(0, 99) < 85)
                    queue_access(make_addr(tag_pool[$urandom_range(0, n_tags - 1)],
                                           row_base + $urandom_range(0, 3),
                                           $urandom()));
                else
                    queue_access($urandom());
            end
            drain();
        end
        repeat (10) @(posedge aclk);

        $display("%0d items checked over %0d register writes and %0d random phases",
                 n_out_accepted, n_cfg_writes, N_PHASES);
        $display("%0d hits, clamped and oversized geometry, FIFO eviction, stalls on both sides",
                 hit_count);
        if (n_errors == 0 && owed_wr == owed_rd) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
